// File: hw/rtl/spi_ra_pkg.sv
package spi_ra_pkg;

    // Field widths of the item, result and configuration channels.
    localparam int CMD_W       = 2;
    localparam int ADDR_W      = 16;
    localparam int COUNT_W     = 3;
    localparam int DATA_W      = 32;
    localparam int TICK_W      = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam int MAX_BYTES_DEF = 4;
    localparam int HEADER_BYTES  = 3;

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Command byte sent as the third header byte.
    localparam logic [7:0] CMD_BYTE_WRITE = 8'h00;
    localparam logic [7:0] CMD_BYTE_READ  = 8'h80;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_TICKS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETUP_TICKS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_TICKS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WGAP_TICKS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RGAP_TICKS  = 3'd4;

    // Configuration reset values.
    localparam logic [TICK_W-1:0] LOW_TICKS_RST   = 10'd10;
    localparam logic [TICK_W-1:0] SETUP_TICKS_RST = 10'd2;
    localparam logic [TICK_W-1:0] HIGH_TICKS_RST  = 10'd8;
    localparam logic [TICK_W-1:0] WGAP_TICKS_RST  = 10'd1;
    localparam logic [TICK_W-1:0] RGAP_TICKS_RST  = 10'd10;

    typedef struct packed {
        logic [TICK_W-1:0] low_ticks;
        logic [TICK_W-1:0] setup_ticks;
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] write_gap_ticks;
        logic [TICK_W-1:0] read_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [ADDR_W-1:0]  reg_address;
        logic [COUNT_W-1:0] byte_count;
        logic [DATA_W-1:0]  write_data;
        logic               miso;
    } t_item;

    typedef struct packed {
        logic              sclk;
        logic              mosi;
        logic              chip_select;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
        logic              start_ignored;
    } t_result;

endpackage

// File: hw/rtl/spi_ra_if.sv
interface spi_ra_item_if import spi_ra_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [ADDR_W-1:0]  reg_address;
    logic [COUNT_W-1:0] byte_count;
    logic [DATA_W-1:0]  write_data;
    logic               miso;

    modport source (output valid, command, reg_address, byte_count, write_data, miso,
                    input ready);
    modport sink (input valid, command, reg_address, byte_count, write_data, miso,
                  output ready);
endinterface

interface spi_ra_result_if import spi_ra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              sclk;
    logic              mosi;
    logic              chip_select;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_data;
    logic              start_ignored;

    modport source (output valid, sclk, mosi, chip_select, busy_res, done_res, read_data,
                    start_ignored, input ready);
    modport sink (input valid, sclk, mosi, chip_select, busy_res, done_res, read_data,
                  start_ignored, output ready);
endinterface

interface spi_ra_cfg_if import spi_ra_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/spi_ra_cfg.sv
module spi_ra_cfg import spi_ra_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [CFG_INDEX_W-1:0] i_index,
    input  logic [CFG_DATA_W-1:0]  i_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_ticks       <= LOW_TICKS_RST;
            r_cfg.setup_ticks     <= SETUP_TICKS_RST;
            r_cfg.high_ticks      <= HIGH_TICKS_RST;
            r_cfg.write_gap_ticks <= WGAP_TICKS_RST;
            r_cfg.read_gap_ticks  <= RGAP_TICKS_RST;
        end else if (i_wr) begin
            // Writes to an index beyond the register list are dropped.
            case (i_index)
                CFG_LOW_TICKS:   r_cfg.low_ticks       <= i_data;
                CFG_SETUP_TICKS: r_cfg.setup_ticks     <= i_data;
                CFG_HIGH_TICKS:  r_cfg.high_ticks      <= i_data;
                CFG_WGAP_TICKS:  r_cfg.write_gap_ticks <= i_data;
                CFG_RGAP_TICKS:  r_cfg.read_gap_ticks  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/spi_ra_engine.sv
module spi_ra_engine import spi_ra_pkg::*; #(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int BYTE_IDX_W = $clog2(HEADER_BYTES + MAX_BYTES);
    localparam int LEN_W      = $clog2(MAX_BYTES + 1);
    localparam int CMP_W      = BYTE_IDX_W + 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOW,
        PH_SETUP,
        PH_HIGH,
        PH_GAP
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [2:0]            r_bit_idx, n_bit_idx;
    logic [BYTE_IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [7:0]            r_shift, n_shift;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [DATA_W-1:0]     r_data, n_data;
    logic [LEN_W-1:0]      r_len, n_len;
    logic                  r_is_read, n_is_read;
    logic [DATA_W-1:0]     r_received, n_received;
    logic                  r_clk_level, n_clk_level;
    logic                  r_data_level, n_data_level;

    logic                  is_start;
    logic [TICK_W-1:0]     tick_inc;
    logic [TICK_W-1:0]     gap;
    logic [TICK_W-1:0]     limit;
    logic                  reached;
    logic                  last_byte;
    logic                  rx_bit;
    logic [LEN_W-1:0]      start_len;
    logic                  done;
    logic                  ignored;

    // Byte sent at a given position of the frame: two address bytes, the
    // command byte, then the data bytes most significant first.
    function automatic logic [7:0] byte_for(input logic [BYTE_IDX_W-1:0] idx,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [DATA_W-1:0] data,
                                            input logic [LEN_W-1:0] len,
                                            input logic rd);
        logic [LEN_W-1:0]  k;
        logic [LEN_W-1:0]  d;
        logic [DATA_W-1:0] sh;
        k  = LEN_W'(idx - BYTE_IDX_W'(HEADER_BYTES));
        d  = len - LEN_W'(1) - k;
        sh = data >> {d, 3'b000};
        if (idx == BYTE_IDX_W'(0)) begin
            return addr[15:8];
        end else if (idx == BYTE_IDX_W'(1)) begin
            return addr[7:0];
        end else if (idx == BYTE_IDX_W'(2)) begin
            return rd ? CMD_BYTE_READ : CMD_BYTE_WRITE;
        end else begin
            return sh[7:0];
        end
    endfunction

    assign is_start  = (i_item.command == CMD_WRITE) || (i_item.command == CMD_READ);
    assign tick_inc  = r_tick + TICK_W'(1);
    assign gap       = r_is_read ? i_cfg.read_gap_ticks : i_cfg.write_gap_ticks;
    assign reached   = (tick_inc >= limit) || (limit == '0);
    assign last_byte = (CMP_W'(r_byte_idx) + CMP_W'(1))
                       >= (CMP_W'(HEADER_BYTES) + CMP_W'(r_len));
    assign rx_bit    = r_is_read && (r_byte_idx >= BYTE_IDX_W'(HEADER_BYTES));

    always_comb begin
        case (r_phase)
            PH_LOW:   limit = i_cfg.low_ticks;
            PH_SETUP: limit = i_cfg.setup_ticks;
            PH_HIGH:  limit = i_cfg.high_ticks;
            PH_GAP:   limit = gap;
            default:  limit = i_cfg.low_ticks;
        endcase
    end

    // Zero bytes is taken as one, anything above the maximum as the maximum.
    always_comb begin
        if (i_item.byte_count == '0) begin
            start_len = LEN_W'(1);
        end else if (32'(i_item.byte_count) > 32'(MAX_BYTES)) begin
            start_len = LEN_W'(MAX_BYTES);
        end else begin
            start_len = LEN_W'(i_item.byte_count);
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_bit_idx    = r_bit_idx;
        n_byte_idx   = r_byte_idx;
        n_shift      = r_shift;
        n_addr       = r_addr;
        n_data       = r_data;
        n_len        = r_len;
        n_is_read    = r_is_read;
        n_received   = r_received;
        n_clk_level  = r_clk_level;
        n_data_level = r_data_level;
        done         = 1'b0;
        ignored      = 1'b0;

        if (i_accept) begin
            if (is_start) begin
                if (r_phase != PH_IDLE) begin
                    ignored = 1'b1;
                end else begin
                    n_addr      = i_item.reg_address;
                    n_data      = i_item.write_data;
                    n_len       = start_len;
                    n_is_read   = (i_item.command == CMD_READ);
                    if (i_item.command == CMD_READ) begin
                        n_received = '0;
                    end
                    n_byte_idx  = '0;
                    n_shift     = byte_for('0, i_item.reg_address, i_item.write_data,
                                           start_len, i_item.command == CMD_READ);
                    n_bit_idx   = '0;
                    n_tick      = '0;
                    n_clk_level = 1'b0;
                    n_phase     = PH_LOW;
                end
            end else if (r_phase != PH_IDLE) begin
                n_tick = reached ? '0 : tick_inc;
                if (reached) begin
                    case (r_phase)
                        PH_LOW: begin
                            if (rx_bit) begin
                                n_shift = {r_shift[6:0], i_item.miso};
                            end else begin
                                n_data_level = r_shift[7];
                                n_shift      = {r_shift[6:0], 1'b0};
                            end
                            n_phase = PH_SETUP;
                        end
                        PH_SETUP: begin
                            n_clk_level = 1'b1;
                            n_phase     = PH_HIGH;
                        end
                        PH_HIGH: begin
                            if (r_bit_idx != 3'd7) begin
                                n_bit_idx   = r_bit_idx + 3'd1;
                                n_clk_level = 1'b0;
                                n_phase     = PH_LOW;
                            end else begin
                                if (rx_bit) begin
                                    n_received = {r_received[DATA_W-9:0], r_shift};
                                end
                                n_bit_idx = '0;
                                if (last_byte) begin
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                end else if (gap == '0) begin
                                    n_byte_idx  = r_byte_idx + BYTE_IDX_W'(1);
                                    n_shift     = byte_for(r_byte_idx + BYTE_IDX_W'(1),
                                                           r_addr, r_data, r_len, r_is_read);
                                    n_clk_level = 1'b0;
                                    n_phase     = PH_LOW;
                                end else begin
                                    n_phase = PH_GAP;
                                end
                            end
                        end
                        PH_GAP: begin
                            n_byte_idx  = r_byte_idx + BYTE_IDX_W'(1);
                            n_shift     = byte_for(r_byte_idx + BYTE_IDX_W'(1),
                                                   r_addr, r_data, r_len, r_is_read);
                            n_bit_idx   = '0;
                            n_clk_level = 1'b0;
                            n_phase     = PH_LOW;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= '0;
            r_bit_idx    <= '0;
            r_byte_idx   <= '0;
            r_shift      <= '0;
            r_addr       <= '0;
            r_data       <= '0;
            r_len        <= '0;
            r_is_read    <= 1'b0;
            r_received   <= '0;
            r_clk_level  <= 1'b1;
            r_data_level <= 1'b1;
        end else begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit_idx    <= n_bit_idx;
            r_byte_idx   <= n_byte_idx;
            r_shift      <= n_shift;
            r_addr       <= n_addr;
            r_data       <= n_data;
            r_len        <= n_len;
            r_is_read    <= n_is_read;
            r_received   <= n_received;
            r_clk_level  <= n_clk_level;
            r_data_level <= n_data_level;
        end
    end

    // The result shows the state as it stands after this item.
    assign o_res.sclk          = n_clk_level;
    assign o_res.mosi          = n_data_level;
    assign o_res.chip_select   = (n_phase != PH_IDLE);
    assign o_res.busy_res      = (n_phase != PH_IDLE);
    assign o_res.done_res      = done;
    assign o_res.read_data     = n_received;
    assign o_res.start_ignored = ignored;

    a_start_lowers_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && is_start && r_phase == PH_IDLE) |=> (r_phase == PH_LOW && !r_clk_level))
        else $error("start did not open the low phase of the first bit");

    a_idle_clock_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE || r_phase == PH_GAP) |-> r_clk_level)
        else $error("serial clock low while idle or between bytes");

    a_done_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (r_phase == PH_HIGH && r_bit_idx == 3'd7 && last_byte))
        else $error("frame ended outside the last bit of the last byte");

endmodule

// File: hw/rtl/spi_register_access_master.sv
// SPI master, clock idling high, that runs register-access frames.
//
// Items arrive on i_item. Command tick advances time by one tick and samples
// miso; start write and start read load a frame (address, byte count and
// write data) and raise chip select. A frame is the address high byte, the
// low byte, a command byte and then the data bytes, all MSB first. A start
// during a frame is dropped and flagged in start_ignored.
// Every accepted transaction yields exactly one result transaction on
// o_result carrying sclk, mosi, chip select, busy, done, read data and the
// ignored flag, as they stand after that item.
// The result becomes valid in the cycle after acceptance, and one item is
// accepted in every cycle while the receiver takes results: the per-tick
// counter and shift logic sit between the frame state registers and a single
// output register. If the receiver stalls, the result is held in the output
// register and i_item.ready falls until it is taken; nothing is lost or
// repeated. Timing registers are written on i_cfg (always ready); the user
// must write them only while the block is idle; the block does not enforce it.
// Reset is synchronous and active low: frame state returns to idle with the
// clock and data lines high, and the timing registers take their defaults.
module spi_register_access_master import spi_ra_pkg::*; #(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    spi_ra_item_if.sink      i_item,
    spi_ra_cfg_if.sink       i_cfg,
    spi_ra_result_if.source  o_result
);

    t_cfg    cfg;
    t_item   item;
    t_result res;
    logic    in_accept;

    t_result r_out;
    logic    r_out_valid;

    // The output register frees up in the same cycle that its result is taken.
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign in_accept    = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    assign item.command     = i_item.command;
    assign item.reg_address = i_item.reg_address;
    assign item.byte_count  = i_item.byte_count;
    assign item.write_data  = i_item.write_data;
    assign item.miso        = i_item.miso;

    spi_ra_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    spi_ra_engine #(
        .MAX_BYTES (MAX_BYTES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    // Result register: loaded on every accepted item, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.sclk          = r_out.sclk;
    assign o_result.mosi          = r_out.mosi;
    assign o_result.chip_select   = r_out.chip_select;
    assign o_result.busy_res      = r_out.busy_res;
    assign o_result.done_res      = r_out.done_res;
    assign o_result.read_data     = r_out.read_data;
    assign o_result.start_ignored = r_out.start_ignored;

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !in_accept)
        else $error("item accepted while a stalled result was pending");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> (!r_out.busy_res && r_out.sclk))
        else $error("frame end reported while still busy or with the clock low");

endmodule
